>>> rtl/core/lss_pkg.sv
// Package with the shared types, codes and default sizes of the LIFO stack with search.
package lss_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int WORD_W    = 32;
    localparam int KIND_W    = 2;
    localparam int OCC_W     = 7;
    localparam int STATUS_W  = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH   = 2'd0,
        KIND_POP    = 2'd1,
        KIND_SEARCH = 2'd2,
        KIND_NOP    = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SRCH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              found;
        logic [OCC_W-1:0]  occupancy;
        logic              empty;
        logic              full;
        t_status           status;
    } t_result;

endpackage

>>> rtl/core/lss_if.sv
// Valid/ready channel interfaces for the stack's operation and result transfers.
interface lss_in_if;
    logic                             valid;
    logic                             ready;
    logic [lss_pkg::KIND_W-1:0]       kind;
    logic signed [lss_pkg::WORD_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface lss_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [lss_pkg::WORD_W-1:0]  result_word;
    logic                               found;
    logic [lss_pkg::OCC_W-1:0]          occupancy;
    logic                               empty_res;
    logic                               full_res;
    logic [lss_pkg::STATUS_W-1:0]       status;

    modport source (output valid, output result_word, output found, output occupancy,
                    output empty_res, output full_res, output status, input ready);
    modport sink   (input valid, input result_word, input found, input occupancy,
                    input empty_res, input full_res, input status, output ready);
endinterface

>>> rtl/core/lss_mem.sv
// Entry memory of the stack: one write port and one registered read port.
module lss_mem #(
    parameter int DEPTH = lss_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [lss_pkg::WORD_W-1:0] i_wr_data,
    input  logic [AW-1:0]              i_rd_addr,
    output logic [lss_pkg::WORD_W-1:0] o_rd_data
);
    import lss_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/lss_seq.sv
// Sequencer of the stack: fill count, top word and the shared compare unit of the search walk.
module lss_seq #(
    parameter int DEPTH = lss_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [lss_pkg::KIND_W-1:0] i_kind,
    input  logic [lss_pkg::WORD_W-1:0] i_value,
    output logic                       o_res_valid,
    input  logic                       i_res_take,
    output lss_pkg::t_result           o_res,
    output logic                       o_mem_wr_en,
    output logic [AW-1:0]              o_mem_wr_addr,
    output logic [lss_pkg::WORD_W-1:0] o_mem_wr_data,
    output logic [AW-1:0]              o_mem_rd_addr,
    input  logic [lss_pkg::WORD_W-1:0] i_mem_rd_data
);
    import lss_pkg::*;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [WORD_W-1:0] r_top, n_top;
    logic [WORD_W-1:0] r_word, n_word;
    logic [WORD_W-1:0] r_key, n_key;
    logic [AW-1:0]     r_idx, n_idx;
    logic              r_found, n_found;
    t_status           r_status, n_status;

    logic accept;
    logic is_empty;
    logic is_full;
    logic hit;
    logic last;

    assign accept   = i_in_valid && o_in_ready;
    assign is_empty = (r_count == '0);
    assign is_full  = (r_count == CW'(DEPTH));
    // The one comparator, reused for every entry of the walk.
    assign hit      = (i_mem_rd_data == r_key);
    assign last     = ((CW'(r_idx) + CW'(1)) == r_count);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (t_kind'(i_kind) == KIND_POP && !is_empty) begin
                        n_state = S_POP;
                    end else if (t_kind'(i_kind) == KIND_SEARCH && !is_empty) begin
                        n_state = S_SRCH;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_POP: begin
                n_state = S_DONE;
            end
            S_SRCH: begin
                if (hit || last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        n_count       = r_count;
        n_top         = r_top;
        n_word        = r_word;
        n_key         = r_key;
        n_idx         = r_idx;
        n_found       = r_found;
        n_status      = r_status;
        o_mem_wr_en   = 1'b0;
        o_mem_wr_addr = r_count[AW-1:0];
        o_mem_wr_data = i_value;
        o_mem_rd_addr = r_idx + AW'(1);
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_found  = 1'b0;
                    n_status = ST_OK;
                    n_word   = r_top;
                    case (t_kind'(i_kind))
                        KIND_PUSH: begin
                            if (is_full) begin
                                n_status = ST_OVER;
                            end else begin
                                o_mem_wr_en = 1'b1;
                                n_count     = r_count + CW'(1);
                                n_top       = i_value;
                                n_word      = i_value;
                            end
                        end
                        KIND_POP: begin
                            if (is_empty) begin
                                n_status = ST_UNDER;
                                n_word   = '0;
                            end else begin
                                n_count       = r_count - CW'(1);
                                o_mem_rd_addr = AW'(r_count - CW'(2));
                            end
                        end
                        KIND_SEARCH: begin
                            n_key         = i_value;
                            n_idx         = '0;
                            o_mem_rd_addr = '0;
                        end
                        default: begin
                            n_word = r_top;
                        end
                    endcase
                end
            end
            S_POP: begin
                n_top = is_empty ? '0 : i_mem_rd_data;
            end
            S_SRCH: begin
                n_found = hit;
                n_idx   = r_idx + AW'(1);
            end
            S_DONE: begin
                n_word = r_word;
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_top   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_top   <= n_top;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word   <= n_word;
        r_key    <= n_key;
        r_idx    <= n_idx;
        r_found  <= n_found;
        r_status <= n_status;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_res.word      = r_word;
        o_res.found     = r_found;
        o_res.occupancy = OCC_W'(r_count);
        o_res.empty     = is_empty;
        o_res.full      = is_full;
        o_res.status    = r_status;
    end

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count beyond depth");

    a_over_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == ST_OVER) |-> is_full)
        else $error("overflow reported while not full");

    a_push_grows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && t_kind'(i_kind) == KIND_PUSH && !is_full)
            |=> (r_count == $past(r_count) + CW'(1)) && (r_top == $past(i_value)))
        else $error("push did not update count and top");

    a_walk_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> (CW'(r_idx) < r_count))
        else $error("search walked past the held entries");

endmodule

>>> rtl/core/lifo_stack_with_search.sv
// Top level of the bounded LIFO stack of 32-bit words with a membership search.
// A push, an overflow, an underflow or the unused operation code goes from the idle state
// straight to the done state; a pop passes through a state that reads the new top word,
// and a search walks the held entries from the oldest, one entry per cycle through the
// single read port of the entry memory, and stops at the first matching entry. The
// sequencer takes a new operation only when idle, after its last result went to the output.
// Synchronous active-low reset empties the stack; the entry memory itself is not cleared.
module lifo_stack_with_search #(
    parameter int DEPTH = lss_pkg::DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lss_in_if.sink    i_in,
    lss_out_if.source o_out
);
    import lss_pkg::*;

    // Address and count widths follow from the depth; the count must be able to hold DEPTH.
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic              mem_wr_en;
    logic [AW-1:0]     mem_wr_addr;
    logic [WORD_W-1:0] mem_wr_data;
    logic [AW-1:0]     mem_rd_addr;
    logic [WORD_W-1:0] mem_rd_data;

    logic    res_valid;
    logic    res_take;
    t_result res;

    // The output register holds one finished result. The sequencer may load a new
    // result whenever the register is empty or its current result is transferred now.
    logic    r_out_valid;
    t_result r_out;

    assign res_take = !r_out_valid || o_out.ready;

    lss_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    lss_seq #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in.valid),
        .o_in_ready    (i_in.ready),
        .i_kind        (i_in.kind),
        .i_value       (i_in.value),
        .o_res_valid   (res_valid),
        .i_res_take    (res_take),
        .o_res         (res),
        .o_mem_wr_en   (mem_wr_en),
        .o_mem_wr_addr (mem_wr_addr),
        .o_mem_wr_data (mem_wr_data),
        .o_mem_rd_addr (mem_rd_addr),
        .i_mem_rd_data (mem_rd_data)
    );

    // Valid flag of the output register is control state and is cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= res_valid;
        end
    end

    // The payload needs no reset; it is only looked at while the valid flag is set.
    always_ff @(posedge i_clk) begin
        if (res_take && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.result_word = r_out.word;
    assign o_out.found       = r_out.found;
    assign o_out.occupancy   = r_out.occupancy;
    assign o_out.empty_res   = r_out.empty;
    assign o_out.full_res    = r_out.full;
    assign o_out.status      = r_out.status;

    // A result appears at the output only after the sequencer has finished one.
    a_out_from_seq : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(res_valid))
        else $error("result offered without a finished operation");

    // A result held back by the sink must not be overwritten.
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result changed");

    // Only a search may report a found entry, and then with status ok.
    a_found_ok : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && res.found) |-> (res.status == ST_OK))
        else $error("found flag set with a fault status");

endmodule
